// File: sv/npb_pkg.sv
// Package for the net bounding box block: word types, register indexes and grid helpers.
package npb_pkg;

    localparam int COORD_W = 10;
    localparam int GRID_W  = 11;
    localparam int WL_W    = 11;
    localparam int CNT_W   = 2;

    // largest grid side honoured; larger settings act as this
    localparam logic [GRID_W-1:0] GRID_MAX = 11'd1024;

    localparam logic [GRID_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
    localparam logic [GRID_W-1:0]  GRID_HEIGHT_RST = 11'd1024;
    localparam logic [COORD_W-1:0] DELTA_CAP_RST   = 10'd10;

    // pin counter saturates here
    localparam logic [CNT_W-1:0] CNT_SAT  = 2'd3;
    localparam logic [CNT_W-1:0] CNT_PAIR = 2'd2;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_DELTA_CAP   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] pin_x;
        logic [COORD_W-1:0] pin_y;
        logic               last_pin;
    } pin_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_bottom;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_top;
        logic [WL_W-1:0]    wirelength;
        logic               feed_through;
    } box_word_t;

    // net summary handed from the tracker to the box stage
    typedef struct packed {
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic               feed_through;
    } net_sum_t;

    // index of the last usable cell for a grid side setting
    function automatic logic [GRID_W-1:0] last_cell(input logic [GRID_W-1:0] g);
        logic [GRID_W-1:0] r;
        if (g == '0)
            r = '0;
        else if (g > GRID_MAX)
            r = GRID_MAX - 11'd1;
        else
            r = g - 11'd1;
        return r;
    endfunction

endpackage

// File: sv/net_pin_bbox_hpwl.sv
// Top level of the net bounding box and half-perimeter wirelength block.
// Pins of a net arrive one word per cycle, last_pin set on the net's final pin; the block
// takes a pin word in every cycle while the result side keeps up, and gives one box word
// per net after its last pin passes the input register, the net summary register and the
// result register. The path is three registers: the input register (pin clamped to the
// grid), the tracker with its net summary register, and the result register after the
// widen-and-clamp logic. Nets follow one another with no gap. Configuration writes take
// effect at once and are meant for an idle block.
module net_pin_bbox_hpwl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [npb_pkg::GRID_W-1:0]  cfg_data,
    input  logic                        pin_valid,
    output logic                        pin_stall,
    input  npb_pkg::pin_word_t          pin_word,
    output logic                        box_valid,
    input  logic                        box_stall,
    output npb_pkg::box_word_t          box_word
);
    import npb_pkg::*;

    logic [GRID_W-1:0]  grid_width_reg, grid_height_reg;
    logic [COORD_W-1:0] delta_cap_reg;
    logic [GRID_W-1:0]  lim_x, lim_y;

    logic       in_vld_reg, in_vld_next;
    pin_word_t  in_word_reg, in_word_next;
    pin_word_t  clamped;
    logic       in_ready, track_ready, box_ready, sum_vld;
    net_sum_t   sum;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            delta_cap_reg   <= DELTA_CAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                REG_DELTA_CAP:   delta_cap_reg   <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign lim_x = last_cell(grid_width_reg);
    assign lim_y = last_cell(grid_height_reg);

    // clamp an incoming pin onto the grid
    always_comb
    begin
        clamped = pin_word;
        if ({1'b0, pin_word.pin_x} > lim_x)
            clamped.pin_x = lim_x[COORD_W-1:0];
        if ({1'b0, pin_word.pin_y} > lim_y)
            clamped.pin_y = lim_y[COORD_W-1:0];
    end

    // input register
    assign in_ready  = !in_vld_reg || track_ready;
    assign pin_stall = !in_ready;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_word_next = in_word_reg;
        if (in_ready)
        begin
            in_vld_next = pin_valid;
            if (pin_valid)
                in_word_next = clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        in_word_reg <= in_word_next;
    end

    npb_track u_track
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (in_vld_reg),
        .in_word     (in_word_reg),
        .box_ready   (box_ready),
        .track_ready (track_ready),
        .sum_vld     (sum_vld),
        .sum         (sum)
    );

    npb_box u_box
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_vld   (sum_vld),
        .sum       (sum),
        .lim_x     (lim_x),
        .lim_y     (lim_y),
        .delta_cap (delta_cap_reg),
        .out_stall (box_stall),
        .box_ready (box_ready),
        .out_vld   (box_valid),
        .out_word  (box_word)
    );

`ifndef SYNTH
    // the widened box never turns inside out
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid |-> (box_word.box_left <= box_word.box_right)
                      && (box_word.box_bottom <= box_word.box_top))
        else $error("box corners out of order");

    // wirelength matches the corners it is sent with
    a_wl_match: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid |-> (box_word.wirelength ==
                       ({1'b0, box_word.box_right} - {1'b0, box_word.box_left})
                       + ({1'b0, box_word.box_top} - {1'b0, box_word.box_bottom})))
        else $error("wirelength does not match box");
`endif

endmodule

// File: sv/npb_track.sv
// Running min/max, pin count and first pin of the current net, with the net summary register.
module npb_track
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  npb_pkg::pin_word_t  in_word,
    input  logic                box_ready,
    output logic                track_ready,
    output logic                sum_vld,
    output npb_pkg::net_sum_t   sum
);
    import npb_pkg::*;

    logic [COORD_W-1:0] min_x_reg, min_x_next;
    logic [COORD_W-1:0] min_y_reg, min_y_next;
    logic [COORD_W-1:0] max_x_reg, max_x_next;
    logic [COORD_W-1:0] max_y_reg, max_y_next;
    logic [COORD_W-1:0] first_x_reg, first_x_next;
    logic [COORD_W-1:0] first_y_reg, first_y_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               sum_vld_reg, sum_vld_next;
    net_sum_t           sum_reg, sum_next;

    logic               take;
    logic [COORD_W-1:0] upd_min_x, upd_min_y, upd_max_x, upd_max_y;
    logic [CNT_W-1:0]   cnt_inc;
    logic               ft;

    assign track_ready = !sum_vld_reg || box_ready;
    assign take        = in_vld && track_ready;

    // box after including this pin
    always_comb
    begin
        upd_min_x = (in_word.pin_x < min_x_reg) ? in_word.pin_x : min_x_reg;
        upd_min_y = (in_word.pin_y < min_y_reg) ? in_word.pin_y : min_y_reg;
        upd_max_x = (in_word.pin_x > max_x_reg) ? in_word.pin_x : max_x_reg;
        upd_max_y = (in_word.pin_y > max_y_reg) ? in_word.pin_y : max_y_reg;
        cnt_inc   = (cnt_reg == CNT_SAT) ? CNT_SAT : cnt_reg + 2'd1;
        ft        = (cnt_inc == CNT_PAIR)
                    && ((first_x_reg == in_word.pin_x) || (first_y_reg == in_word.pin_y));
    end

    // next state: accumulate, or close the net on its last pin
    always_comb
    begin
        min_x_next   = min_x_reg;
        min_y_next   = min_y_reg;
        max_x_next   = max_x_reg;
        max_y_next   = max_y_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        sum_vld_next = sum_vld_reg;
        if (box_ready)
            sum_vld_next = 1'b0;
        if (take)
        begin
            if (in_word.last_pin)
            begin
                min_x_next   = '1;
                min_y_next   = '1;
                max_x_next   = '0;
                max_y_next   = '0;
                first_x_next = '0;
                first_y_next = '0;
                cnt_next     = '0;
                sum_next     = '{min_x: upd_min_x, min_y: upd_min_y,
                                 max_x: upd_max_x, max_y: upd_max_y,
                                 feed_through: ft};
                sum_vld_next = 1'b1;
            end
            else
            begin
                min_x_next = upd_min_x;
                min_y_next = upd_min_y;
                max_x_next = upd_max_x;
                max_y_next = upd_max_y;
                cnt_next   = cnt_inc;
                if (cnt_reg == '0)
                begin
                    first_x_next = in_word.pin_x;
                    first_y_next = in_word.pin_y;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg   <= '1;
            min_y_reg   <= '1;
            max_x_reg   <= '0;
            max_y_reg   <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            cnt_reg     <= '0;
            sum_vld_reg <= 1'b0;
        end
        else
        begin
            min_x_reg   <= min_x_next;
            min_y_reg   <= min_y_next;
            max_x_reg   <= max_x_next;
            max_y_reg   <= max_y_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            cnt_reg     <= cnt_next;
            sum_vld_reg <= sum_vld_next;
        end
    end

    // summary payload, no reset
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum_vld = sum_vld_reg;
    assign sum     = sum_reg;

`ifndef SYNTH
    // closing a net leaves fresh tracking state
    a_net_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_word.last_pin) |=> (cnt_reg == '0) && (min_x_reg == '1)
                                       && (max_y_reg == '0))
        else $error("tracking state not cleared after last pin");

    // a summary waiting on the box stage is held
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_vld_reg && !box_ready) |=> (sum_vld_reg && $stable(sum_reg)))
        else $error("net summary lost while box stage busy");
`endif

endmodule

// File: sv/npb_box.sv
// Widens and clamps the net box, forms the wirelength and holds the result word.
module npb_box
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sum_vld,
    input  npb_pkg::net_sum_t           sum,
    input  logic [npb_pkg::GRID_W-1:0]  lim_x,
    input  logic [npb_pkg::GRID_W-1:0]  lim_y,
    input  logic [npb_pkg::COORD_W-1:0] delta_cap,
    input  logic                        out_stall,
    output logic                        box_ready,
    output logic                        out_vld,
    output npb_pkg::box_word_t          out_word
);
    import npb_pkg::*;

    logic        out_vld_reg, out_vld_next;
    box_word_t   out_word_reg, out_word_next;

    logic [COORD_W-1:0] dx, dy, d, left, bottom;
    logic [GRID_W-1:0]  right_w, top_w, right, top;
    logic [WL_W-1:0]    wl;

    assign box_ready = !out_vld_reg || !out_stall;

    // relaxation: larger of the two capped spans
    always_comb
    begin
        dx = sum.max_x - sum.min_x;
        dy = sum.max_y - sum.min_y;
        if (dx > delta_cap)
            dx = delta_cap;
        if (dy > delta_cap)
            dy = delta_cap;
        d = (dx > dy) ? dx : dy;
    end

    // widened box, clamped to the grid
    always_comb
    begin
        left    = (sum.min_x > d) ? sum.min_x - d : '0;
        bottom  = (sum.min_y > d) ? sum.min_y - d : '0;
        right_w = {1'b0, sum.max_x} + {1'b0, d};
        top_w   = {1'b0, sum.max_y} + {1'b0, d};
        right   = (right_w > lim_x) ? lim_x : right_w;
        top     = (top_w > lim_y) ? lim_y : top_w;
        wl      = (right - {1'b0, left}) + (top - {1'b0, bottom});
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_word_next = out_word_reg;
        if (box_ready)
        begin
            out_vld_next = sum_vld;
            if (sum_vld)
                out_word_next = '{box_left: left, box_bottom: bottom,
                                  box_right: right[COORD_W-1:0], box_top: top[COORD_W-1:0],
                                  wirelength: wl, feed_through: sum.feed_through};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_vld  = out_vld_reg;
    assign out_word = out_word_reg;

endmodule
